// File: rtl/modbus_read_response_parser_defines.svh
// ----------------------------------------------------------------------------
// Modbus read response parser assertion macros
// Shared property wrappers for same-cycle and next-cycle checks.
// ----------------------------------------------------------------------------
`ifndef MODBUS_READ_RESPONSE_PARSER_DEFINES_SVH
`define MODBUS_READ_RESPONSE_PARSER_DEFINES_SVH

// same-cycle implication
`define MBRRP_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed: name");

// next-cycle implication
`define MBRRP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed: name");

`endif

// File: rtl/mbrrp_pkg.sv
// ----------------------------------------------------------------------------
// Modbus read response parser package
// Frame layout positions, protocol constants and the result record.
// ----------------------------------------------------------------------------
package mbrrp_pkg;

  localparam int unsigned PosW = 9;

  localparam logic [PosW-1:0] PosTidHi  = 9'd0;
  localparam logic [PosW-1:0] PosTidLo  = 9'd1;
  localparam logic [PosW-1:0] PosPidHi  = 9'd2;
  localparam logic [PosW-1:0] PosPidLo  = 9'd3;
  localparam logic [PosW-1:0] PosLenHi  = 9'd4;
  localparam logic [PosW-1:0] PosLenLo  = 9'd5;
  localparam logic [PosW-1:0] PosUnit   = 9'd6;
  localparam logic [PosW-1:0] PosFunc   = 9'd7;
  localparam logic [PosW-1:0] PosCount  = 9'd8;
  localparam logic [PosW-1:0] PosMax    = 9'd511;

  localparam logic [PosW-1:0] MinFrame  = 9'd9;
  localparam logic [PosW-1:0] HdrBias   = 9'd6;
  localparam logic [7:0]      FcReadHolding = 8'h03;

  localparam int unsigned QueueDepthDefault = 2;

  typedef struct packed {
    logic        reg_valid;
    logic [15:0] reg_value;
    logic [6:0]  reg_index;
    logic        frame_done;
    logic        frame_ok;
    logic [15:0] resp_transaction;
    logic [7:0]  resp_unit;
  } rsp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// File: rtl/mbrrp_front.sv
// ----------------------------------------------------------------------------
// Modbus read response parser front end
// Tracks the frame position, checks the header and assembles registers.
// ----------------------------------------------------------------------------
module mbrrp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  logic [7:0]         data_byte_i,
  input  logic               frame_end_i,
  input  logic [15:0]        expect_transaction_i,
  input  logic [7:0]         expect_unit_i,
  output logic               push_o,
  output mbrrp_pkg::rsp_t    rsp_o
);
  import mbrrp_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     ltr_q, ltr_d;
  logic [7:0]      lunit_q, lunit_d;
  logic [15:0]     htr_q, htr_d;
  logic [15:0]     hlen_q, hlen_d;
  logic [7:0]      hunit_q, hunit_d;
  logic [7:0]      pcnt_q, pcnt_d;
  logic [7:0]      pend_q, pend_d;
  logic            err_q, err_d;

  logic            rv;
  logic [15:0]     rval;
  logic [6:0]      ridx;
  logic [PosW-1:0] off;
  logic [PosW-1:0] total;
  logic            ok;

  assign off   = pos_q - MinFrame;
  assign total = (pos_q != PosMax) ? pos_q + 9'd1 : PosMax;

  always_comb begin
    ltr_d   = ltr_q;
    lunit_d = lunit_q;
    htr_d   = htr_q;
    hlen_d  = hlen_q;
    hunit_d = hunit_q;
    pcnt_d  = pcnt_q;
    pend_d  = pend_q;
    err_d   = err_q;
    rv      = 1'b0;
    rval    = '0;
    ridx    = '0;
    case (pos_q)
      PosTidHi: begin
        ltr_d   = expect_transaction_i;
        lunit_d = expect_unit_i;
        htr_d   = {data_byte_i, 8'h00};
        hlen_d  = '0;
        hunit_d = '0;
        pcnt_d  = '0;
        pend_d  = '0;
        err_d   = 1'b0;
      end
      PosTidLo: begin
        htr_d = {htr_q[15:8], data_byte_i};
        if (htr_d != ltr_q) err_d = 1'b1;
      end
      PosPidHi, PosPidLo: begin
        if (data_byte_i != 8'h00) err_d = 1'b1;
      end
      PosLenHi: hlen_d = {data_byte_i, 8'h00};
      PosLenLo: hlen_d = {hlen_q[15:8], data_byte_i};
      PosUnit: begin
        hunit_d = data_byte_i;
        if (data_byte_i != lunit_q) err_d = 1'b1;
      end
      PosFunc: begin
        if (data_byte_i != FcReadHolding) err_d = 1'b1;
      end
      PosCount: begin
        pcnt_d = data_byte_i;
        if (data_byte_i[0]) err_d = 1'b1;
      end
      default: begin
        if ({1'b0, pos_q} < ({1'b0, MinFrame} + {2'b00, pcnt_q})) begin
          if (!off[0]) begin
            pend_d = data_byte_i;
          end else begin
            rv   = 1'b1;
            rval = {pend_q, data_byte_i};
            ridx = off[7:1];
          end
        end
      end
    endcase

    ok = !err_d && (total >= MinFrame)
         && ({8'h00, total} == ({8'h00, HdrBias} + {1'b0, hlen_d}))
         && ({1'b0, total} == ({1'b0, MinFrame} + {2'b00, pcnt_d}));

    if (frame_end_i) begin
      pos_d = '0;
    end else if (pos_q != PosMax) begin
      pos_d = pos_q + 9'd1;
    end else begin
      pos_d = pos_q;
    end
  end

  assign push_o = acc_i && (rv || frame_end_i);

  always_comb begin
    rsp_o.reg_valid        = rv;
    rsp_o.reg_value        = rval;
    rsp_o.reg_index        = ridx;
    rsp_o.frame_done       = frame_end_i;
    rsp_o.frame_ok         = frame_end_i && ok;
    rsp_o.resp_transaction = htr_d;
    rsp_o.resp_unit        = hunit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ltr_q   <= '0;
      lunit_q <= '0;
      htr_q   <= '0;
      hlen_q  <= '0;
      hunit_q <= '0;
      pcnt_q  <= '0;
      pend_q  <= '0;
      err_q   <= 1'b0;
    end else if (acc_i) begin
      pos_q   <= pos_d;
      ltr_q   <= ltr_d;
      lunit_q <= lunit_d;
      htr_q   <= htr_d;
      hlen_q  <= hlen_d;
      hunit_q <= hunit_d;
      pcnt_q  <= pcnt_d;
      pend_q  <= pend_d;
      err_q   <= err_d;
    end
  end

endmodule

// File: rtl/mbrrp_queue.sv
// ----------------------------------------------------------------------------
// Modbus read response parser result queue
// Short FIFO of result records between the front end and the output stage.
// ----------------------------------------------------------------------------
module mbrrp_queue #(
  parameter int unsigned Depth = mbrrp_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mbrrp_pkg::rsp_t     wdata_i,
  input  logic                pop_i,
  output mbrrp_pkg::rsp_t     rdata_o,
  output mbrrp_pkg::qstat_t   stat_o
);
  import mbrrp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  rsp_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;

  assign stat_o.full  = (cnt_q == CntFull);
  assign stat_o.empty = (cnt_q == '0);
  assign do_pop       = pop_i && !stat_o.empty;
  assign rdata_o      = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
      end
      case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: rtl/mbrrp_back.sv
// ----------------------------------------------------------------------------
// Modbus read response parser output stage
// Pulls results from the queue into the output register and drives valid.
// ----------------------------------------------------------------------------
module mbrrp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mbrrp_pkg::qstat_t   stat_i,
  input  mbrrp_pkg::rsp_t     rdata_i,
  output logic                pop_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output mbrrp_pkg::rsp_t     rsp_o
);
  import mbrrp_pkg::*;

  logic valid_q;
  rsp_t rsp_q;

  assign pop_o       = !stat_i.empty && (!valid_q || !out_stall_i);
  assign out_valid_o = valid_q;
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rsp_q <= rdata_i;
    end
  end

endmodule

// File: rtl/modbus_read_response_parser.sv
// ----------------------------------------------------------------------------
// Modbus TCP read-holding-registers response parser
// Parses response frames byte by byte, emits registers and a frame verdict.
// ----------------------------------------------------------------------------
// Input channel: one frame byte per request on in_valid_i / in_stall_o, with
// frame_end_i set on the last byte. expect_transaction_i and expect_unit_i
// are sampled on the first byte of each frame.
// Output channel: out_valid_o / out_stall_i. A result appears for each byte
// that completes a register and for the last byte of a frame; other bytes
// give none. On frame_done_o, frame_ok_o = 0 means the registers already
// delivered for that frame must be dropped.
// Throughput: one byte per cycle while in_stall_o is low. A result is written
// to the queue at the edge that takes its byte and then moves on into the
// output register once that register is empty or not stalled.
// Stall: results wait in the QueueDepth-entry queue; in_stall_o rises when
// the queue is full and falls as soon as the output stage frees an entry.
// Reset: all parser state clears to the start of a frame, the queue empties
// and out_valid_o drops.
// ----------------------------------------------------------------------------
`include "modbus_read_response_parser_defines.svh"

module modbus_read_response_parser #(
  parameter int unsigned QueueDepth = mbrrp_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_end_i,
  input  logic [15:0] expect_transaction_i,
  input  logic [7:0]  expect_unit_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        reg_valid_o,
  output logic [15:0] reg_value_o,
  output logic [6:0]  reg_index_o,
  output logic        frame_done_o,
  output logic        frame_ok_o,
  output logic [15:0] resp_transaction_o,
  output logic [7:0]  resp_unit_o
);
  import mbrrp_pkg::*;

  logic   acc;
  logic   push;
  logic   pop;
  rsp_t   front_rsp;
  rsp_t   q_rsp;
  rsp_t   out_rsp;
  qstat_t qstat;

  assign in_stall_o = qstat.full;
  assign acc        = in_valid_i && !in_stall_o;

  mbrrp_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .acc_i                (acc),
    .data_byte_i          (data_byte_i),
    .frame_end_i          (frame_end_i),
    .expect_transaction_i (expect_transaction_i),
    .expect_unit_i        (expect_unit_i),
    .push_o               (push),
    .rsp_o                (front_rsp)
  );

  mbrrp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_rsp),
    .pop_i   (pop),
    .rdata_o (q_rsp),
    .stat_o  (qstat)
  );

  mbrrp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (qstat),
    .rdata_i     (q_rsp),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .rsp_o       (out_rsp)
  );

  assign reg_valid_o        = out_rsp.reg_valid;
  assign reg_value_o        = out_rsp.reg_value;
  assign reg_index_o        = out_rsp.reg_index;
  assign frame_done_o       = out_rsp.frame_done;
  assign frame_ok_o         = out_rsp.frame_ok;
  assign resp_transaction_o = out_rsp.resp_transaction;
  assign resp_unit_o        = out_rsp.resp_unit;

  `MBRRP_ASSERT_NOW(a_no_overflow, clk_i, rst_ni, push, !qstat.full)
  `MBRRP_ASSERT_NOW(a_qstat_sane, clk_i, rst_ni, 1'b1, !(qstat.full && qstat.empty))
  `MBRRP_ASSERT_NEXT(a_fill_output, clk_i, rst_ni, !out_valid_o && !qstat.empty, out_valid_o)
  `MBRRP_ASSERT_NOW(a_ok_needs_done, clk_i, rst_ni, out_valid_o && frame_ok_o, frame_done_o)

endmodule
